// File: sv/dbf_pkg.sv
// Shared constants, types and the CRC-8 helper of the baseband framer.
package dbf_pkg;

  localparam int unsigned PACKET_BYTES_DEF = 188;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned LEN_W            = 13;
  localparam int unsigned ROLL_W           = 2;
  localparam int unsigned CFG_ADDR_W       = 2;
  localparam int unsigned HDR_LEN          = 10;
  localparam int unsigned HIDX_W           = 4;

  localparam logic [BYTE_W-1:0] CRC8_GEN   = 8'hD5;
  localparam logic [BYTE_W-1:0] TS_SYNC    = 8'h47;
  localparam logic [3:0]        MATYPE_HI  = 4'hF;

  localparam logic [LEN_W-1:0]  DFB_RESET  = 13'd7264;
  localparam logic [ROLL_W-1:0] ROLL_RESET = 2'b11;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DATA_FIELD_BYTES = 2'd0,
    REG_ROLLOFF_CODE     = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              sync_error;
    logic              frame_last;
    logic              needs_header;
    logic [BYTE_W-1:0] carry_bytes;
  } dbf_item_t;

  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data_in);
    logic [BYTE_W-1:0] c;
    c = crc_in ^ data_in;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC8_GEN;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: sv/dvbs2_ts_baseband_framer_unit.sv
// Top level of the DVB-S2 transport stream baseband framer with BBHEADER and CRC-8.
//
// Channel   Direction  Payload
// in_       slave      tdata[7:0] ts_byte
// out_      master     tdata[7:0] frame_byte, tuser[0] is_header, tuser[1] sync_error,
//                      tlast frame_last
// cfg_      write      addr 0 data_field_bytes, addr 1 rolloff_code
//
// One input transaction is taken per cycle while the output does not stall; the first byte of each frame
// holds the input while the header sequencer emits the ten BBHEADER bytes.
// Output stalls propagate to in_tready through the single pending-item register.
// Reset is synchronous; the block takes input from the first cycle after it.
module dvbs2_ts_baseband_framer_unit #(
  parameter int unsigned PACKET_BYTES = dbf_pkg::PACKET_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] ts_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // [7:0] frame_byte
  output logic [1:0]                        out_tuser,  // [0] is_header, [1] sync_error
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [dbf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [dbf_pkg::LEN_W-1:0]         cfg_wdata
);

  localparam logic [15:0] UPL = 16'(PACKET_BYTES * 8);
  localparam logic [dbf_pkg::HIDX_W-1:0] HDR_DONE = dbf_pkg::HIDX_W'(dbf_pkg::HDR_LEN);

  logic [dbf_pkg::LEN_W-1:0]  dfb_r;
  logic [dbf_pkg::ROLL_W-1:0] roll_r;
  logic [dbf_pkg::LEN_W-1:0]  frame_len;
  logic [15:0]                dfl;
  logic [15:0]                syncd;

  dbf_pkg::dbf_item_t         in_item;
  dbf_pkg::dbf_item_t         pend_r;
  logic                       pend_valid_r, pend_valid_nxt;
  logic [dbf_pkg::HIDX_W-1:0] hidx_r, hidx_nxt;
  logic [dbf_pkg::BYTE_W-1:0] hcrc_r, hcrc_nxt;
  logic [dbf_pkg::BYTE_W-1:0] hdr_byte;

  logic                       out_valid_r;
  logic [7:0]                 out_byte_r;
  logic                       out_hdr_r, out_last_r, out_err_r;

  logic out_load, emit, hdr_phase, emit_hdr, emit_data, accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dfb_r  <= dbf_pkg::DFB_RESET;
      roll_r <= dbf_pkg::ROLL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dbf_pkg::REG_DATA_FIELD_BYTES: dfb_r  <= cfg_wdata;
        dbf_pkg::REG_ROLLOFF_CODE:     roll_r <= cfg_wdata[dbf_pkg::ROLL_W-1:0];
        default: ;
      endcase
    end
  end

  assign frame_len = (dfb_r == '0) ? dbf_pkg::LEN_W'(1) : dfb_r;
  assign dfl       = {frame_len, 3'b000};
  assign syncd     = {5'b0, pend_r.carry_bytes, 3'b000};

  assign out_load  = !out_valid_r || out_tready;
  assign emit      = pend_valid_r && out_load;
  assign hdr_phase = pend_r.needs_header && (hidx_r != HDR_DONE);
  assign emit_hdr  = emit && hdr_phase;
  assign emit_data = emit && !hdr_phase;
  assign in_tready = !pend_valid_r || emit_data;
  assign accept    = in_tvalid && in_tready;

  dbf_ingest #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_ingest (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .ts_byte  (in_tdata),
    .frame_len(frame_len),
    .item     (in_item)
  );

  always_comb begin
    case (hidx_r)
      4'd0:    hdr_byte = {dbf_pkg::MATYPE_HI, 2'b00, roll_r};
      4'd1:    hdr_byte = 8'h00;
      4'd2:    hdr_byte = UPL[15:8];
      4'd3:    hdr_byte = UPL[7:0];
      4'd4:    hdr_byte = dfl[15:8];
      4'd5:    hdr_byte = dfl[7:0];
      4'd6:    hdr_byte = dbf_pkg::TS_SYNC;
      4'd7:    hdr_byte = syncd[15:8];
      4'd8:    hdr_byte = syncd[7:0];
      default: hdr_byte = hcrc_r;
    endcase
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    hidx_nxt       = hidx_r;
    hcrc_nxt       = hcrc_r;
    if (emit_hdr) begin
      hidx_nxt = hidx_r + 1'b1;
      hcrc_nxt = dbf_pkg::crc8_byte((hidx_r == '0) ? '0 : hcrc_r, hdr_byte);
    end
    if (emit_data) begin
      pend_valid_nxt = 1'b0;
      hidx_nxt       = '0;
    end
    if (accept) begin
      pend_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      hidx_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      hidx_r       <= hidx_nxt;
      if (out_load) begin
        out_valid_r <= pend_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    hcrc_r <= hcrc_nxt;
    if (accept) begin
      pend_r <= in_item;
    end
    if (emit) begin
      out_byte_r <= hdr_phase ? hdr_byte : pend_r.data_byte;
      out_hdr_r  <= hdr_phase;
      out_last_r <= !hdr_phase && pend_r.frame_last;
      out_err_r  <= !hdr_phase && pend_r.sync_error;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_err_r, out_hdr_r};
  assign out_tlast  = out_last_r;

  a_hdr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_hdr_r |-> !out_last_r && !out_err_r)
    else $error("Header byte flagged as last or as sync error.");

  a_hidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hidx_r != '0 |-> pend_valid_r && pend_r.needs_header && hidx_r <= HDR_DONE)
    else $error("Header index out of step with the pending item.");

  a_hdr_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r && hdr_phase |-> !in_tready)
    else $error("Input taken while header bytes are outstanding.");

endmodule

// File: sv/dbf_ingest.sv
// Input-side packet and frame tracking: sync byte replacement and frame boundaries.
module dbf_ingest #(
  parameter int unsigned PACKET_BYTES = dbf_pkg::PACKET_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [dbf_pkg::BYTE_W-1:0]    ts_byte,
  input  logic [dbf_pkg::LEN_W-1:0]     frame_len,
  output dbf_pkg::dbf_item_t            item
);

  localparam logic [dbf_pkg::BYTE_W-1:0] PKT_RELOAD = dbf_pkg::BYTE_W'(PACKET_BYTES - 1);

  logic [dbf_pkg::LEN_W-1:0]  frame_pos_r, frame_pos_nxt;
  logic [dbf_pkg::BYTE_W-1:0] pkt_left_r, pkt_left_nxt;
  logic [dbf_pkg::BYTE_W-1:0] pkt_crc_r, pkt_crc_nxt;
  logic [dbf_pkg::LEN_W-1:0]  pos_inc;
  logic                       frame_end;

  always_comb begin
    item.needs_header = (frame_pos_r == '0);
    item.carry_bytes  = pkt_left_r;
    if (pkt_left_r == '0) begin
      item.sync_error = (ts_byte != dbf_pkg::TS_SYNC);
      item.data_byte  = pkt_crc_r;
      pkt_crc_nxt     = '0;
      pkt_left_nxt    = PKT_RELOAD;
    end else begin
      item.sync_error = 1'b0;
      item.data_byte  = ts_byte;
      pkt_crc_nxt     = dbf_pkg::crc8_byte(pkt_crc_r, ts_byte);
      pkt_left_nxt    = pkt_left_r - 1'b1;
    end
    pos_inc         = frame_pos_r + 1'b1;
    frame_end       = (pos_inc >= frame_len) || (pos_inc == '0);
    item.frame_last = frame_end;
    frame_pos_nxt   = frame_end ? '0 : pos_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_pos_r <= '0;
      pkt_left_r  <= '0;
      pkt_crc_r   <= '0;
    end else if (accept) begin
      frame_pos_r <= frame_pos_nxt;
      pkt_left_r  <= pkt_left_nxt;
      pkt_crc_r   <= pkt_crc_nxt;
    end
  end

endmodule
